>>> hdl/vnb_pkg.sv
package vnb_pkg;

  localparam int POS_FRAC = 14;
  localparam int POS_ONE  = 2 ** POS_FRAC;

  localparam int STOP_LO = -((POS_ONE + 10) / 20);
  localparam int STOP_HI = (27 * POS_ONE + 12) / 25;

  localparam int VEL_W   = 24;
  localparam int VEL_MAX = 2 ** (VEL_W - 1) - 1;
  localparam int VEL_MIN = -(2 ** (VEL_W - 1));

  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 24;
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = MUL_B_W / MUL_DIGIT;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam int TGT_W = 15;

  localparam logic REG_NATURAL_FREQUENCY = 1'b0;
  localparam logic REG_DAMPING_RATIO     = 1'b1;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

endpackage

>>> hdl/vnb_serial_mul.sv
module vnb_serial_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  vnb_pkg::mul_a_t a,
  input  vnb_pkg::mul_b_t b,
  output logic            busy,
  output vnb_pkg::mul_p_t product
);

  localparam int ACC_W = vnb_pkg::MUL_A_W + vnb_pkg::MUL_DIGIT + 1;
  localparam int CNT_W = $clog2(vnb_pkg::MUL_STEPS);

  vnb_pkg::mul_a_t                   a_r;
  logic [vnb_pkg::MUL_B_W-1:0]       b_r;
  logic [vnb_pkg::MUL_B_W-1:0]       low;
  logic signed [ACC_W-1:0]           acc;
  logic [CNT_W-1:0]                  cnt;
  logic                              last;
  logic signed [vnb_pkg::MUL_DIGIT:0] dig;
  logic signed [ACC_W:0]             term;
  logic signed [ACC_W:0]             sum;

  // The top digit of the multiplier carries its sign weight.
  always_comb begin
    last = (cnt == CNT_W'(vnb_pkg::MUL_STEPS - 1));
    if (last) begin
      dig = $signed({b_r[vnb_pkg::MUL_DIGIT-1], b_r[vnb_pkg::MUL_DIGIT-1:0]});
    end else begin
      dig = $signed({1'b0, b_r[vnb_pkg::MUL_DIGIT-1:0]});
    end
    term = a_r * dig;
    sum  = acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      acc <= ACC_W'(sum >>> vnb_pkg::MUL_DIGIT);
      low <= {sum[vnb_pkg::MUL_DIGIT-1:0], low[vnb_pkg::MUL_B_W-1:vnb_pkg::MUL_DIGIT]};
      b_r <= b_r >> vnb_pkg::MUL_DIGIT;
    end
  end

  assign product = {acc[vnb_pkg::MUL_A_W-1:0], low};

endmodule

>>> hdl/vnb_level_map.sv
module vnb_level_map (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [15:0]         level,
  output logic                       busy,
  output logic [vnb_pkg::TGT_W-1:0]  target
);

  localparam int NUM_W = 17;
  localparam int DEN_W = 17;
  localparam int N_W   = NUM_W + vnb_pkg::POS_FRAC;
  localparam int Q_W   = vnb_pkg::TGT_W;
  localparam int CNT_W = $clog2(Q_W);

  logic signed [17:0]  dlev;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [N_W-1:0]      nval;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem;
  logic [Q_W-1:0]      qsh;
  logic [CNT_W-1:0]    cnt;
  logic [DEN_W:0]      trial;
  logic                ge;

  // Each scale segment is one exact ratio; the flat ends divide by one.
  always_comb begin
    dlev = {{2{level[15]}}, level};
    num  = '0;
    den  = DEN_W'(1);
    nval = '0;
    if (dlev >= 18'sd0) begin
      nval = N_W'(vnb_pkg::POS_ONE);
    end else if (dlev <= -18'sd7680) begin
      nval = '0;
    end else begin
      if (dlev >= -18'sd1280) begin
        num = NUM_W'(dlev + 18'sd5120);
        den = DEN_W'(5120);
      end else if (dlev >= -18'sd2560) begin
        num = NUM_W'(66560 + 23 * (dlev + 18'sd2560));
        den = DEN_W'(128000);
      end else if (dlev >= -18'sd5120) begin
        num = NUM_W'(5632 + 3 * (dlev + 18'sd5120));
        den = DEN_W'(25600);
      end else begin
        num = NUM_W'(11 * (dlev + 18'sd7680));
        den = DEN_W'(128000);
      end
      nval = (N_W'(num) << vnb_pkg::POS_FRAC) + N_W'(den >> 1);
    end
  end

  always_comb begin
    trial = {rem, qsh[Q_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(Q_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; the quotient
  // shifts in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(nval[N_W-1:Q_W]);
      qsh   <= nval[Q_W-1:0];
      den_r <= den;
    end else if (busy) begin
      if (ge) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      qsh <= {qsh[Q_W-2:0], ge};
    end
  end

  assign target = qsh;

endmodule

>>> hdl/vu_needle_ballistics.sv
// The input is taken only while idle, so one item is processed at a time: each item makes six
// passes through the shared radix-16 serial multiplier and one through the serial level divider.
// A finished result waits in the output register while the next item runs.
// Reset is synchronous and active high: needle at 1.0, speed zero, registers
// at 20.0 rad/s and damping 1.0, output empty.
module vu_needle_ballistics (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // gain_reduction_db[15:0], time_step[35:16], zero[39:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // needle_position[15:0], target_position[30:16],
                                     // needle_speed[54:31], zero[55]
  output logic [0:0]  m_axis_tuser   // at_end_stop[0]
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WW   = 4'd1;
  localparam logic [3:0] ST_ZW   = 4'd2;
  localparam logic [3:0] ST_TGT  = 4'd3;
  localparam logic [3:0] ST_SPR  = 4'd4;
  localparam logic [3:0] ST_DMP  = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_DV   = 4'd7;
  localparam logic [3:0] ST_SAT  = 4'd8;
  localparam logic [3:0] ST_DP   = 4'd9;
  localparam logic [3:0] ST_CLP  = 4'd10;

  logic [3:0]                 state;
  logic [3:0]                 state_next;
  logic [15:0]                wn;
  logic [15:0]                zeta;
  logic [19:0]                dt;
  logic [31:0]                ww;
  logic [31:0]                zw;
  logic [vnb_pkg::TGT_W-1:0]  target;
  logic signed [33:0]         spring;
  logic signed [37:0]         damp;
  logic signed [39:0]         dv;
  logic signed [23:0]         vnew;
  logic signed [24:0]         dp;
  logic signed [15:0]         position;
  logic signed [23:0]         velocity;
  logic signed [15:0]         out_pos;
  logic [vnb_pkg::TGT_W-1:0]  out_tgt;
  logic signed [23:0]         out_vel;
  logic                       out_stop;

  logic                       in_xfer;
  logic                       out_free;
  logic                       mul_start;
  logic                       mul_busy;
  logic                       map_start;
  logic                       map_busy;
  vnb_pkg::mul_a_t            mul_a;
  vnb_pkg::mul_b_t            mul_b;
  vnb_pkg::mul_p_t            prod;
  logic [vnb_pkg::TGT_W-1:0]  map_target;
  logic signed [16:0]         diff;
  logic signed [39:0]         acc_val;
  logic signed [40:0]         vsum;
  logic signed [23:0]         vsat;
  logic signed [25:0]         psum;
  logic signed [15:0]         pos_clamped;
  logic                       stop;
  logic signed [63:0]         prod_r16;
  logic signed [63:0]         prod_r19;
  logic signed [63:0]         prod_r20;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  vnb_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (prod)
  );

  vnb_level_map u_map (
    .clk    (clk),
    .rst    (rst),
    .start  (map_start),
    .level  ($signed(s_axis_tdata[15:0])),
    .busy   (map_busy),
    .target (map_target)
  );

  // Rounding to nearest with ties toward plus infinity.
  always_comb begin
    prod_r16 = (prod + 64'sd32768) >>> 16;
    prod_r19 = (prod + 64'sd262144) >>> 19;
    prod_r20 = (prod + 64'sd524288) >>> 20;
  end

  always_comb begin
    diff    = $signed({2'b00, map_target}) - $signed({position[15], position});
    acc_val = $signed({{6{spring[33]}}, spring}) - $signed({{2{damp[37]}}, damp});
    vsum    = $signed({{17{velocity[23]}}, velocity}) + $signed({dv[39], dv});
    if (vsum > 41'(vnb_pkg::VEL_MAX)) begin
      vsat = 24'(vnb_pkg::VEL_MAX);
    end else if (vsum < 41'(vnb_pkg::VEL_MIN)) begin
      vsat = 24'(vnb_pkg::VEL_MIN);
    end else begin
      vsat = vsum[23:0];
    end
    psum = $signed({{10{position[15]}}, position}) + $signed({dp[24], dp});
    stop = 1'b0;
    pos_clamped = psum[15:0];
    if (psum < 26'(vnb_pkg::STOP_LO)) begin
      pos_clamped = 16'(vnb_pkg::STOP_LO);
      stop        = 1'b1;
    end else if (psum > 26'(vnb_pkg::STOP_HI)) begin
      pos_clamped = 16'(vnb_pkg::STOP_HI);
      stop        = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    map_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          map_start  = 1'b1;
          mul_start  = 1'b1;
          mul_a      = {24'b0, wn};
          mul_b      = {8'b0, wn};
          state_next = ST_WW;
        end
      end
      ST_WW: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_a      = {24'b0, zeta};
          mul_b      = {8'b0, wn};
          state_next = ST_ZW;
        end
      end
      ST_ZW: begin
        if (!mul_busy) begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        if (!map_busy) begin
          mul_start  = 1'b1;
          mul_a      = {8'b0, ww};
          mul_b      = {{7{diff[16]}}, diff};
          state_next = ST_SPR;
        end
      end
      ST_SPR: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_a      = {8'b0, zw};
          mul_b      = velocity;
          state_next = ST_DMP;
        end
      end
      ST_DMP: begin
        if (!mul_busy) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        mul_start  = 1'b1;
        mul_a      = acc_val;
        mul_b      = {4'b0, dt};
        state_next = ST_DV;
      end
      ST_DV: begin
        if (!mul_busy) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        mul_start  = 1'b1;
        mul_a      = {{16{vsat[23]}}, vsat};
        mul_b      = {4'b0, dt};
        state_next = ST_DP;
      end
      ST_DP: begin
        if (!mul_busy) begin
          state_next = ST_CLP;
        end
      end
      ST_CLP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wn            <= 16'd5120;
      zeta          <= 16'd4096;
      position      <= 16'(vnb_pkg::POS_ONE);
      velocity      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          vnb_pkg::REG_NATURAL_FREQUENCY: wn   <= cfg_data;
          vnb_pkg::REG_DAMPING_RATIO:     zeta <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_CLP && out_free) begin
        position      <= pos_clamped;
        velocity      <= stop ? '0 : vnew;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dt <= s_axis_tdata[35:16];
    end
    if (state == ST_WW && !mul_busy) begin
      ww <= prod[31:0];
    end
    if (state == ST_ZW && !mul_busy) begin
      zw <= prod[31:0];
    end
    if (state == ST_TGT && !map_busy) begin
      target <= map_target;
    end
    if (state == ST_SPR && !mul_busy) begin
      spring <= prod_r16[33:0];
    end
    if (state == ST_DMP && !mul_busy) begin
      damp <= prod_r19[37:0];
    end
    if (state == ST_DV && !mul_busy) begin
      dv <= prod_r20[39:0];
    end
    if (state == ST_SAT) begin
      vnew <= vsat;
    end
    if (state == ST_DP && !mul_busy) begin
      dp <= prod_r20[24:0];
    end
    if (state == ST_CLP && out_free) begin
      out_pos  <= pos_clamped;
      out_tgt  <= target;
      out_vel  <= stop ? '0 : vnew;
      out_stop <= stop;
    end
  end

  assign m_axis_tdata = {1'b0, out_vel, out_tgt, out_pos};
  assign m_axis_tuser = out_stop;

endmodule

>>> hdl/vnb_checker.sv
module vnb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) >= 16'(vnb_pkg::STOP_LO)
      && $signed(m_axis_tdata[15:0]) <= 16'(vnb_pkg::STOP_HI))
    else $error("needle position outside the end stops");

  a_stop_zero_speed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[54:31] == 24'd0)
    else $error("end stop with nonzero speed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind vu_needle_ballistics vnb_checker u_vnb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
